@@ sv/wpd_pkg.sv @@
// Shared types and constants of the waveform peak decimator.
package wpd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TOP_W       = 12;
  localparam int HEIGHT_W    = 13;
  localparam int HALF_W      = HEIGHT_W - 1;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 12;
  localparam int CHUNK_W     = 16;
  localparam int ROW_W       = 13;
  localparam int ROW_MAX     = (1 << ROW_W) - 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // magnitude * gain, then * half height, then scaled back down
  localparam int P1_W  = SAMPLE_BITS + GAIN_W;
  localparam int P2_W  = P1_W + HALF_W;
  localparam int SHIFT = SAMPLE_BITS - 1 + GAIN_FRAC;
  localparam int Q_W   = P2_W - SHIFT;
  // signed working width for row arithmetic
  localparam int CALC_W = Q_W + 3;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [TOP_W-1:0]    WINDOW_TOP_RST    = '0;
  localparam logic [HEIGHT_W-1:0] WINDOW_HEIGHT_RST = HEIGHT_W'(128);
  localparam logic [GAIN_W-1:0]   GAIN_RST          = GAIN_W'(4096);
  localparam logic [CHUNK_W-1:0]  CHUNK_LENGTH_RST  = CHUNK_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_TOP    = 2'd0,
    CFG_WINDOW_HEIGHT = 2'd1,
    CFG_GAIN          = 2'd2,
    CFG_CHUNK_LENGTH  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [TOP_W-1:0]    window_top;
    logic [HEIGHT_W-1:0] window_height;
    logic [GAIN_W-1:0]   gain;
    logic [CHUNK_W-1:0]  chunk_length;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          final_sample;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] upper_row;
    logic [ROW_W-1:0] lower_row;
    logic             partial_chunk;
    logic             last_column;
  } out_item_t;

  // one finished chunk on its way from front to back
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] pos_mag;
    logic [SAMPLE_BITS-1:0] neg_mag;
    logic                   partial;
    logic                   last;
  } col_t;

endpackage

@@ sv/wpd_front.sv @@
// Front end: chunk position counting and peak tracking per sample.
module wpd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  wpd_pkg::in_item_t             in_item,
  input  logic [wpd_pkg::CHUNK_W-1:0]   chunk_length,
  output logic                          col_push,
  output wpd_pkg::col_t                 col
);
  import wpd_pkg::*;

  logic [CHUNK_W-1:0]            pos_r;
  logic signed [SAMPLE_BITS-1:0] pk_pos_r;
  logic signed [SAMPLE_BITS-1:0] pk_neg_r;
  logic signed [SAMPLE_BITS-1:0] pk_pos_nxt;
  logic signed [SAMPLE_BITS-1:0] pk_neg_nxt;
  logic                          chunk_end;
  logic                          closes;

  assign chunk_end = ({1'b0, pos_r} + (CHUNK_W + 1)'(1)) >= {1'b0, chunk_length};
  assign closes    = chunk_end || in_item.final_sample;

  // left channel only: even positions counted from chunk start
  always_comb begin
    pk_pos_nxt = pk_pos_r;
    pk_neg_nxt = pk_neg_r;
    if (!pos_r[0]) begin
      if (in_item.sample > pk_pos_r) pk_pos_nxt = in_item.sample;
      else if (in_item.sample <= pk_neg_r) pk_neg_nxt = in_item.sample;
    end
  end

  assign col_push    = take && closes;
  assign col.pos_mag = pk_pos_nxt;
  assign col.neg_mag = SAMPLE_BITS'(-pk_neg_nxt);
  assign col.partial = !chunk_end;
  assign col.last    = in_item.final_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      pk_pos_r <= '0;
      pk_neg_r <= '0;
    end else if (take) begin
      if (closes) begin
        pos_r    <= '0;
        pk_pos_r <= '0;
        pk_neg_r <= '0;
      end else begin
        pos_r    <= pos_r + CHUNK_W'(1);
        pk_pos_r <= pk_pos_nxt;
        pk_neg_r <= pk_neg_nxt;
      end
    end
  end

endmodule

@@ sv/wpd_fifo.sv @@
// Short register queue of finished chunks between front and back.
module wpd_fifo #(
  parameter int DEPTH = wpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  wpd_pkg::col_t wr_data,
  input  logic          rd,
  output wpd_pkg::col_t rd_data,
  output logic          full,
  output logic          empty
);
  import wpd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  col_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = count_r == CNT_W'(DEPTH);
  assign empty   = count_r == '0;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (rd) rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (wr && !rd)      count_r <= count_r + CNT_W'(1);
      else if (rd && !wr) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

@@ sv/wpd_back.sv @@
// Back end: scales each chunk's peaks into display rows and holds the result.
module wpd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  wpd_pkg::cfg_t      cfg,
  input  wpd_pkg::col_t      head,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output wpd_pkg::out_item_t out_item
);
  import wpd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_GAIN,
    ST_MUL_HALF,
    ST_ROUND,
    ST_DONE
  } state_t;

  state_t                    state_r;
  logic                      side_r;   // 0: upper row, 1: lower row
  col_t                      col_r;
  logic [P2_W-1:0]           prod_r;
  logic [ROW_W-1:0]          upper_r;
  logic [ROW_W-1:0]          lower_r;
  logic                      out_valid_r;
  out_item_t                 out_item_r;

  logic [HALF_W-1:0]         half;
  logic [SAMPLE_BITS-1:0]    mag;
  logic [P1_W-1:0]           gain_prod;
  logic [Q_W-1:0]            q_floor;
  logic signed [CALC_W-1:0]  top_s;
  logic signed [CALC_W-1:0]  centre_s;
  logic signed [CALC_W-1:0]  bottom_s;
  logic signed [CALC_W-1:0]  q_floor_s;
  logic signed [CALC_W-1:0]  q_ceil_s;
  logic signed [CALC_W-1:0]  up_s;
  logic signed [CALC_W-1:0]  lo_s;
  logic                      pop_ok;
  logic                      load_out;

  function automatic logic [ROW_W-1:0] clamp_row(input logic signed [CALC_W-1:0] r);
    logic [ROW_W-1:0] res;
    if (r < 0) res = '0;
    else if (r > signed'(CALC_W'(ROW_MAX))) res = ROW_W'(ROW_MAX);
    else res = r[ROW_W-1:0];
    return res;
  endfunction

  assign half      = cfg.window_height[HEIGHT_W-1:1];
  assign mag       = side_r ? col_r.neg_mag : col_r.pos_mag;
  assign gain_prod = P1_W'(mag) * P1_W'(cfg.gain);
  assign q_floor   = prod_r[P2_W-1:SHIFT];

  always_comb begin
    top_s     = signed'(CALC_W'(cfg.window_top));
    centre_s  = top_s + signed'(CALC_W'(half));
    bottom_s  = top_s + signed'(CALC_W'(cfg.window_height)) - signed'(CALC_W'(1));
    q_floor_s = signed'(CALC_W'(q_floor));
    q_ceil_s  = q_floor_s + signed'(CALC_W'(|prod_r[SHIFT-1:0]));
    up_s      = centre_s - q_ceil_s;
    if (up_s < top_s) up_s = top_s;
    lo_s      = centre_s + q_floor_s;
    if (lo_s > bottom_s) lo_s = bottom_s;
  end

  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign pop_ok   = pop && out_valid_r;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || pop_ok);
  assign empty    = !out_valid_r;
  assign out_item = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= load_out || (out_valid_r && !pop_ok);
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            col_r  <= head;
            side_r <= 1'b0;
            if (head.partial) begin
              upper_r <= clamp_row(centre_s);
              lower_r <= clamp_row(centre_s);
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_MUL_GAIN;
            end
          end
        end
        ST_MUL_GAIN: begin
          prod_r  <= P2_W'(gain_prod);
          state_r <= ST_MUL_HALF;
        end
        ST_MUL_HALF: begin
          prod_r  <= P2_W'(prod_r[P1_W-1:0]) * P2_W'(half);
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          if (!side_r) begin
            upper_r <= clamp_row(up_s);
            side_r  <= 1'b1;
            state_r <= ST_MUL_GAIN;
          end else begin
            lower_r <= clamp_row(lo_s);
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_item_r.upper_row     <= upper_r;
            out_item_r.lower_row     <= lower_r;
            out_item_r.partial_chunk <= col_r.partial;
            out_item_r.last_column   <= col_r.last;
            state_r                  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ sv/waveform_peak_decimator.sv @@
// Top level of the min/max peak decimator for waveform display columns.
//
//   channel  | handshake            | beat
//   ---------+----------------------+-------------------------------------------
//   input    | push / full          | in_item: sample, final_sample
//   result   | empty / pop          | out_item: upper_row, lower_row, flags
//   config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// The front takes one input beat per clock while the chunk queue has room.
// The back takes a complete column through gain multiply, half-height
// multiply and rounding, once per row, and a partial one straight to done.
// A waiting result lets the back finish one more column, then holds it there;
// the queue then fills and full holds off the input. Reset is synchronous.
module waveform_peak_decimator #(
  parameter int QUEUE_DEPTH = wpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input samples
  input  logic                            push,
  output logic                            full,
  input  wpd_pkg::in_item_t               in_item,
  // display columns
  output logic                            empty,
  input  logic                            pop,
  output wpd_pkg::out_item_t              out_item,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  wpd_pkg::cfg_reg_e               cfg_index,
  input  logic [wpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wpd_pkg::*;

  cfg_t cfg_r;
  logic take;
  logic col_push;
  col_t col;
  col_t q_head;
  logic q_full;
  logic q_empty;
  logic q_pop;

  // registers take effect on the write; the block does not hold them back until the next column the back starts
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_top    <= WINDOW_TOP_RST;
      cfg_r.window_height <= WINDOW_HEIGHT_RST;
      cfg_r.gain          <= GAIN_RST;
      cfg_r.chunk_length  <= CHUNK_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW_TOP:    cfg_r.window_top    <= cfg_data[TOP_W-1:0];
        CFG_WINDOW_HEIGHT: cfg_r.window_height <= cfg_data[HEIGHT_W-1:0];
        CFG_GAIN:          cfg_r.gain          <= cfg_data[GAIN_W-1:0];
        CFG_CHUNK_LENGTH:  cfg_r.chunk_length  <= cfg_data[CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  // conservative: hold off input whenever the queue is full, even for
  // beats that would not close a chunk
  assign full = q_full;
  assign take = push && !q_full;

  wpd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .in_item      (in_item),
    .chunk_length (cfg_r.chunk_length),
    .col_push     (col_push),
    .col          (col)
  );

  wpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (col_push),
    .wr_data (col),
    .rd      (q_pop),
    .rd_data (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  wpd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

@@ sv/wpd_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
module wpd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               empty,
  input logic               pop,
  input wpd_pkg::out_item_t out_item
);
  import wpd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result channel not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting column changed or vanished before pop");

  a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.partial_chunk) |-> out_item.last_column)
    else $error("partial column not marked as last");

  a_partial_centre: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.partial_chunk) |-> (out_item.upper_row == out_item.lower_row))
    else $error("partial column rows differ");

endmodule

bind waveform_peak_decimator wpd_checker u_wpd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

@@ tb/tb_waveform_peak_decimator.sv @@
// Self-checking testbench for waveform_peak_decimator: column predictor and scoreboard.
module tb_waveform_peak_decimator;
  timeunit 1ns;
  timeprecision 1ps;

  import wpd_pkg::*;

  // cycles allowed after the last column for the back end to go quiet
  localparam int DRAIN_SLACK = 40;
  // long receiver hold-off used by the back-pressure test
  localparam int HOLD_OFF_CYCLES = 100;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  in_item_t           in_item = '0;
  logic               empty;
  logic               pop = 1'b0;
  out_item_t          out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_reg_e           cfg_index = CFG_WINDOW_TOP;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  waveform_peak_decimator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the register file, as the block should hold it after reset.
  logic [TOP_W-1:0]    win_top    = WINDOW_TOP_RST;
  logic [HEIGHT_W-1:0] win_height = WINDOW_HEIGHT_RST;
  logic [GAIN_W-1:0]   win_gain   = GAIN_RST;
  logic [CHUNK_W-1:0]  chunk_len  = CHUNK_LENGTH_RST;

  // Mirror of the per-chunk accumulator.
  logic [CHUNK_W-1:0]            chunk_pos = '0;
  logic signed [SAMPLE_BITS-1:0] pos_peak  = '0;
  logic signed [SAMPLE_BITS-1:0] neg_peak  = '0;

  // Columns predicted but not yet popped, oldest first.
  out_item_t column_q[$];

  int errors        = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // set by a test to make the receiver hold off; cleared once taken up
  int hold_request  = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Rows are clamped into the 13-bit range after the window saturation.
  function automatic logic [ROW_W-1:0] row_clamp(input longint r);
    if (r < 0) return '0;
    if (r > ROW_MAX) return ROW_W'(ROW_MAX);
    return r[ROW_W-1:0];
  endfunction

  // Advances the accumulator by one sample beat; returns 1 when a column
  // falls out, with the predicted column in col.
  function automatic bit decimate_sample(input in_item_t it, output out_item_t col);
    longint half, top, centre, bottom, up, lo, pos_prod, neg_prod;
    bit     at_end;
    half   = longint'(win_height >> 1);
    top    = longint'(win_top);
    centre = top + half;
    bottom = top + longint'(win_height) - 1;
    at_end = (int'(chunk_pos) + 1) >= int'(chunk_len);
    col    = '0;

    // left channel only: even positions counted from the chunk start
    if (!chunk_pos[0]) begin
      if (it.sample > pos_peak)
        pos_peak = it.sample;
      else if (it.sample <= neg_peak)
        neg_peak = it.sample;
    end

    if (at_end) begin
      pos_prod = longint'(pos_peak) * longint'(win_gain) * half;
      neg_prod = -longint'(neg_peak) * longint'(win_gain) * half;
      // upper row rounds the deflection up, lower row rounds it down
      up = centre - ((pos_prod + (longint'(1) << SHIFT) - 1) >> SHIFT);
      lo = centre + (neg_prod >> SHIFT);
      if (up < top) up = top;
      if (lo > bottom) lo = bottom;
      col.upper_row     = row_clamp(up);
      col.lower_row     = row_clamp(lo);
      col.partial_chunk = 1'b0;
      col.last_column   = it.final_sample;
      {chunk_pos, pos_peak, neg_peak} = '0;
      return 1'b1;
    end

    // wave ends mid-chunk: flat column at the centre line
    if (it.final_sample) begin
      col.upper_row     = row_clamp(centre);
      col.lower_row     = row_clamp(centre);
      col.partial_chunk = 1'b1;
      col.last_column   = 1'b1;
      {chunk_pos, pos_peak, neg_peak} = '0;
      return 1'b1;
    end

    chunk_pos = chunk_pos + 1'b1;
    return 1'b0;
  endfunction

  // Offers one sample beat, with random gaps ahead of it, and predicts on
  // acceptance. push is left high so back-to-back beats need no re-raise.
  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic fin);
    out_item_t col;
    in_item_t  it;
    it = '{sample: s, final_sample: fin};
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    if (decimate_sample(it, col))
      column_q.push_back(col);
  endtask

  // Lowers push, then waits for every predicted column and the back end's tail.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (column_q.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // One register beat; cfg_valid stays high so writes can follow back to back.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WINDOW_TOP:    win_top    = val[TOP_W-1:0];
      CFG_WINDOW_HEIGHT: win_height = val[HEIGHT_W-1:0];
      CFG_GAIN:          win_gain   = val[GAIN_W-1:0];
      CFG_CHUNK_LENGTH:  chunk_len  = val[CHUNK_W-1:0];
      default: ;
    endcase
  endtask

  // Rewrites all four registers; only ever called with the block idle.
  task automatic set_window(input logic [CFG_DATA_W-1:0] top_d, height_d, gain_d, len_d);
    write_reg(CFG_WINDOW_TOP, top_d);
    write_reg(CFG_WINDOW_HEIGHT, height_d);
    write_reg(CFG_GAIN, gain_d);
    write_reg(CFG_CHUNK_LENGTH, len_d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Full-scale values, zero and small levels, but mostly uniform values.
  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return SAMPLE_BITS'($signed($urandom_range(64)) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Reset register values: chunk of two, unity gain, 128-row window at row 0.
  task automatic test_reset_defaults();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh0001, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh0005, 1'b0);
    push_sample('0, 1'b0);
    push_sample('0, 1'b0);
    // wave ends on the first beat of a chunk: flat partial column
    push_sample(16'sh0064, 1'b1);
    wait_drained();
  endtask

  // Field and register extremes: saturation at top and bottom, zero height.
  task automatic test_field_extremes();
    set_window(16'd4095, 16'd8191, 16'hFFFF, 16'd1);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    // last beat closes a complete chunk
    push_sample(16'shFFFF, 1'b1);
    wait_drained();
    // zero gain, zero height, chunk length zero: every beat its own column
    set_window(16'd0, 16'd0, 16'd0, 16'd0);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    wait_drained();
  endtask

  // Odd chunk length (parity from chunk start) and a height of one row.
  task automatic test_odd_chunks();
    set_window(16'd100, 16'd1, 16'd4096, 16'd3);
    push_sample(16'sh00C8, 1'b0);
    push_sample(-16'sd300, 1'b0);   // odd position, right channel: ignored
    push_sample(-16'sd400, 1'b0);
    push_sample(16'sh0005, 1'b1);
    wait_drained();
    set_window(16'd5, 16'd4096, 16'd4096, 16'd4);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample('0, 1'b1);
    wait_drained();
  endtask

  // The longest chunk lengths, each cut short by the end of the wave.
  task automatic test_long_chunk();
    set_window(16'd0, 16'd4096, 16'hFFFF, 16'hFFFF);
    for (int k = 0; k < 59; k++)
      push_sample(draw_sample(), 1'b0);
    push_sample(draw_sample(), 1'b1);
    wait_drained();
    set_window(16'd2000, 16'd300, 16'd8192, 16'd65534);
    for (int k = 0; k < 99; k++)
      push_sample(draw_sample(), 1'b0);
    push_sample(draw_sample(), 1'b1);
    wait_drained();
  endtask

  // Receiver stalls for a long stretch while beats keep coming, so the
  // column queue fills and full must hold the sender off.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_window(16'd0, 16'd128, 16'd4096, 16'd2);
    hold_request = HOLD_OFF_CYCLES;
    for (int k = 0; k < 40; k++)
      push_sample(draw_sample(), k == 39);
    // sender pauses here until every column has come out
    wait_drained();
  endtask

  // Random waves under the given idling: each wave gets fresh registers,
  // random samples and ends with final_sample; a few stray final flags
  // land mid-wave.
  task automatic test_random_waves(input int s_pct, input int r_pct, input int n_beats);
    int                  sent, wave_len;
    logic [TOP_W-1:0]    top_v;
    logic [HEIGHT_W-1:0] height_v;
    logic [GAIN_W-1:0]   gain_v;
    logic [CHUNK_W-1:0]  len_v;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_beats) begin
      case ($urandom_range(3))
        0:       top_v = '0;
        1:       top_v = '1;
        default: top_v = TOP_W'($urandom);
      endcase
      case ($urandom_range(7))
        0:       height_v = '0;
        1:       height_v = HEIGHT_W'(1);
        2:       height_v = '1;
        3:       height_v = HEIGHT_W'(4096);
        default: height_v = HEIGHT_W'($urandom_range(2, 4096));
      endcase
      case ($urandom_range(3))
        0:       gain_v = GAIN_RST;
        1:       gain_v = $urandom_range(1) ? '1 : '0;
        default: gain_v = GAIN_W'($urandom);
      endcase
      case ($urandom_range(15))
        0:       len_v = '0;
        1:       len_v = CHUNK_W'(1);
        2:       len_v = CHUNK_W'(2 * $urandom_range(1, 7) + 1);
        3:       len_v = CHUNK_W'($urandom_range(65534, 65535));
        4:       len_v = CHUNK_W'($urandom_range(17, 64));
        default: len_v = CHUNK_W'(2 * $urandom_range(1, 8));
      endcase
      // spare upper data bits carry noise the registers must drop
      set_window({4'($urandom), top_v}, {3'($urandom), height_v}, gain_v, len_v);
      wave_len = $urandom_range(8, 60);
      for (int k = 0; k < wave_len; k++)
        push_sample(draw_sample(), (k == wave_len - 1) || ($urandom_range(99) < 2));
      sent += wave_len;
      wait_drained();
    end
  endtask

  // Result side: checks each popped beat against the oldest prediction and
  // decides pop for the next cycle, honouring any hold-off request.
  initial begin : column_sink
    int        stall;
    out_item_t want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        if (column_q.size() == 0) begin
          errors++;
          $error("column with no prediction waiting: upper_row %0d lower_row %0d",
                 out_item.upper_row, out_item.lower_row);
        end else begin
          want = column_q.pop_front();
          if (out_item.upper_row !== want.upper_row) begin
            errors++;
            $error("upper_row: expected %0d, actual %0d", want.upper_row, out_item.upper_row);
          end
          if (out_item.lower_row !== want.lower_row) begin
            errors++;
            $error("lower_row: expected %0d, actual %0d", want.lower_row, out_item.lower_row);
          end
          if (out_item.partial_chunk !== want.partial_chunk) begin
            errors++;
            $error("partial_chunk: expected %0d, actual %0d",
                   want.partial_chunk, out_item.partial_chunk);
          end
          if (out_item.last_column !== want.last_column) begin
            errors++;
            $error("last_column: expected %0d, actual %0d",
                   want.last_column, out_item.last_column);
          end
        end
      end
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_odd_chunks();
    test_long_chunk();
    test_backpressure();
    test_random_waves(34, 77, 220);
    test_random_waves(77, 34, 220);
    test_random_waves(0, 0, 220);
    wait_drained();
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
